// File: rtl/text_console_glyph_renderer_assert.svh
// assertion macros for the text console glyph renderer
// used by the top level only, no other dependencies
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TCGR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TCGR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tcgr_pkg.sv
// shared types, codes and constants of the text console glyph renderer
// no dependencies
`default_nettype none

package tcgr_pkg;

  // defaults of the top level parameters
  localparam int GLYPH_COUNT_DEF    = 128;
  localparam int MAX_SCREEN_DIM_DEF = 4096;

  // geometry and widths
  localparam int CELL        = 8;
  localparam int DIM_W       = 13;
  localparam int POS_W       = 12;
  localparam int COLOR_W     = 32;
  localparam int QUEUE_DEPTH = 4;

  // control character codes
  localparam logic [7:0] CODE_TAB     = 8'd9;
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_RETURN  = 8'd13;

  // register reset values
  localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd480;
  localparam logic [COLOR_W-1:0] FORE_RST   = 32'h00FF_FFFF;
  localparam logic [COLOR_W-1:0] BACK_RST   = 32'h00FF_0000;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_PRINT  = 2'd0,
    OP_CURSOR = 2'd1,
    OP_LOAD   = 2'd2,
    OP_NONE   = 2'd3
  } tcgr_op_t;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_FORE   = 2'd2,
    REG_BACK   = 2'd3
  } tcgr_reg_t;

  // command kind carried by the queue
  typedef enum logic {
    CMD_DRAW = 1'b0,
    CMD_LOAD = 1'b1
  } tcgr_cmd_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BS_IDLE  = 2'd0,
    BS_FETCH = 2'd1,
    BS_DRAW  = 2'd2
  } tcgr_bstate_t;

  // input item
  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [6:0]  glyph_index;
    logic [2:0]  glyph_row;
    logic [7:0]  glyph_bits;
  } tcgr_item_t;

  // result item, one pixel write
  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] pixel_color;
    logic        last_pixel;
  } tcgr_pixel_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } tcgr_q_stat_t;

endpackage

`default_nettype wire

// File: rtl/text_console_glyph_renderer.sv
// Text console glyph renderer, 8x8 font.
// Input channel (in_valid/in_ready/in_item): one operation per transfer:
// print a character, set the cursor, or load one glyph row into the font.
// Result channel (out_valid/out_ready/out_pixel): one pixel write per
// transfer, 64 per drawn glyph, last_pixel marks the 64th.
// APB-style register port: screen_width at 0x0, screen_height at 0x4,
// fore_color at 0x8, back_color at 0xc; write only while the block is idle.
// Cursor updates and control characters are handled in the front end alone.
// Draw and load commands pass through a 4-entry queue to the back end.
// A glyph runs in the back end as a font read, a fetch step, then 64 pixels
// at one per cycle while the receiver does not stall. A print reaches its
// first pixel through the queue, the font read, the fetch step and the
// output register. A font load is written as it leaves the queue.
// The front end keeps accepting while the queue has room, so a stalled
// receiver first fills the output register, then the queue, then drops
// in_ready. Reset clears cursor, queue and pending pixels and loads the
// register defaults; the font store holds undefined data until loaded.
// depends on tcgr_pkg, tcgr_front, tcgr_fifo, tcgr_back, tcgr_ram
`default_nettype none

`include "text_console_glyph_renderer_assert.svh"

module text_console_glyph_renderer
  import tcgr_pkg::*;
#(
  parameter int GLYPH_COUNT    = GLYPH_COUNT_DEF,
  parameter int MAX_SCREEN_DIM = MAX_SCREEN_DIM_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  tcgr_item_t       in_item,
  output logic             in_ready,
  output logic             out_valid,
  output tcgr_pixel_t      out_pixel,
  input  wire logic        out_ready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = $clog2(GLYPH_COUNT * CELL);
  localparam int QW = 1 + 2 * POS_W + AW + 8;

  logic [DIM_W-1:0]   width_r, height_r;
  logic [COLOR_W-1:0] fore_r, back_r;
  logic               cfg_wr;
  tcgr_reg_t          reg_sel;

  logic         q_push, q_pop;
  logic [QW-1:0] q_wdata, q_head;
  tcgr_q_stat_t q_stat;

  // register port
  assign pready  = 1'b1;
  assign reg_sel = tcgr_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      fore_r   <= FORE_RST;
      back_r   <= BACK_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        REG_FORE:   fore_r   <= pwdata;
        REG_BACK:   back_r   <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = {{(32 - DIM_W){1'b0}}, width_r};
      REG_HEIGHT: prdata = {{(32 - DIM_W){1'b0}}, height_r};
      REG_FORE:   prdata = fore_r;
      REG_BACK:   prdata = back_r;
      default:    prdata = '0;
    endcase
  end

  tcgr_front #(
    .GLYPH_COUNT   (GLYPH_COUNT),
    .MAX_SCREEN_DIM(MAX_SCREEN_DIM),
    .AW            (AW),
    .QW            (QW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_item      (in_item),
    .in_ready     (in_ready),
    .screen_width (width_r),
    .screen_height(height_r),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .q_stat       (q_stat)
  );

  tcgr_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .head_data(q_head),
    .stat     (q_stat)
  );

  tcgr_back #(
    .GLYPH_COUNT(GLYPH_COUNT),
    .AW         (AW),
    .QW         (QW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .fore_color(fore_r),
    .back_color(back_r),
    .out_valid (out_valid),
    .out_pixel (out_pixel),
    .out_ready (out_ready)
  );

  // checks
  `TCGR_ASSERT_IMP(a_no_push_full, clk, rst_n, q_push, !q_stat.full, "push into full queue")
  `TCGR_ASSERT_IMP(a_no_pop_empty, clk, rst_n, q_pop, !q_stat.empty, "pop from empty queue")
  `TCGR_ASSERT_NXT(a_last_spacing, clk, rst_n,
                   out_valid && out_ready && out_pixel.last_pixel,
                   !out_valid || !out_pixel.last_pixel, "back to back last pixels")

endmodule

`default_nettype wire

// File: rtl/tcgr_ram.sv
// generic single write port, single read port RAM with registered read
// no dependencies
`default_nettype none

module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/tcgr_fifo.sv
// short command queue between the front end and the back end
// depends on tcgr_pkg for the status struct
`default_nettype none

module tcgr_fifo
  import tcgr_pkg::*;
#(
  parameter int WIDTH = 44,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head_data,
  output tcgr_q_stat_t          stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data  = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

`default_nettype wire

// File: rtl/tcgr_front.sv
// front end: accepts items, keeps the cursor, queues draw and font load commands
// depends on tcgr_pkg
`default_nettype none

module tcgr_front
  import tcgr_pkg::*;
#(
  parameter int GLYPH_COUNT    = GLYPH_COUNT_DEF,
  parameter int MAX_SCREEN_DIM = MAX_SCREEN_DIM_DEF,
  parameter int AW             = $clog2(GLYPH_COUNT * CELL),
  parameter int QW             = 1 + 2 * POS_W + AW + 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  tcgr_item_t            in_item,
  output logic                  in_ready,
  input  wire logic [DIM_W-1:0] screen_width,
  input  wire logic [DIM_W-1:0] screen_height,
  output logic                  q_push,
  output logic      [QW-1:0]    q_data,
  input  tcgr_q_stat_t          q_stat
);

  // extended width so that position plus cell never overflows
  localparam int EW = DIM_W + 2;
  localparam logic [EW-1:0] MAX_DIM = EW'(MAX_SCREEN_DIM);
  localparam logic [EW-1:0] CELL_E  = EW'(CELL);
  localparam logic [EW-1:0] TAB_E   = EW'(4 * CELL);

  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;

  logic [EW-1:0] w_eff, h_eff;
  logic [EW-1:0] col_e, row_e;
  logic [EW-1:0] nl_row;
  logic [EW-1:0] tab_col;
  logic          tab_wrap;
  logic          pre_wrap;
  logic [EW-1:0] col1, row1, col2, row2;
  logic          fits;
  logic          accept;
  logic [10:0]   draw_addr_full, load_addr_full;
  logic [AW-1:0] draw_addr, load_addr;
  logic          load_ok;

  // move down one text line, back to the top when the next line does not fit
  function automatic logic [EW-1:0] next_row(input logic [EW-1:0] row,
                                             input logic [EW-1:0] h);
    logic [EW-1:0] r;
    r = row + CELL_E;
    if (r + CELL_E > h) begin
      r = '0;
    end
    return r;
  endfunction

  // effective screen size, saturated
  assign w_eff = ({2'b00, screen_width} > MAX_DIM) ? MAX_DIM : {2'b00, screen_width};
  assign h_eff = ({2'b00, screen_height} > MAX_DIM) ? MAX_DIM : {2'b00, screen_height};

  assign col_e  = {2'b00, col_r};
  assign row_e  = {2'b00, row_r};
  assign nl_row = next_row(row_e, h_eff);

  // tab target: four cells on, aligned to a cell
  assign tab_col  = {col_e[EW-1:3], 3'b000} + TAB_E;
  assign tab_wrap = (tab_col + CELL_E > w_eff);

  // printable character placement
  assign pre_wrap = (col_e + CELL_E > w_eff);
  assign col1     = pre_wrap ? '0 : col_e;
  assign row1     = pre_wrap ? nl_row : row_e;
  assign row2     = (row1 + CELL_E > h_eff) ? '0 : row1;
  assign col2     = (col1 + CELL_E > w_eff) ? '0 : col1;
  assign fits     = (col2 + CELL_E <= w_eff) && (row2 + CELL_E <= h_eff);

  // font store addresses, codes out of range use glyph zero
  assign draw_addr_full = (9'({1'b0, in_item.char_code}) < 9'(GLYPH_COUNT)) ?
                          {in_item.char_code, 3'b000} : '0;
  assign draw_addr      = draw_addr_full[AW-1:0];
  assign load_ok        = (9'(in_item.glyph_index) < 9'(GLYPH_COUNT));
  assign load_addr_full = {1'b0, in_item.glyph_index, in_item.glyph_row};
  assign load_addr      = load_addr_full[AW-1:0];

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // classify the item, update the cursor, build the queue entry
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    q_push  = 1'b0;
    q_data  = {CMD_DRAW, col2[POS_W-1:0], row2[POS_W-1:0], draw_addr, 8'h00};
    if (accept) begin
      case (tcgr_op_t'(in_item.operation))
        OP_CURSOR: begin
          col_nxt = {1'b0, in_item.pos_x};
          row_nxt = {1'b0, in_item.pos_y};
        end
        OP_LOAD: begin
          q_push = load_ok;
          q_data = {CMD_LOAD, {POS_W{1'b0}}, {POS_W{1'b0}}, load_addr,
                    in_item.glyph_bits};
        end
        OP_PRINT: begin
          if (in_item.char_code == CODE_NEWLINE) begin
            col_nxt = '0;
            row_nxt = nl_row[DIM_W-1:0];
          end else if (in_item.char_code == CODE_RETURN) begin
            col_nxt = '0;
          end else if (in_item.char_code == CODE_TAB) begin
            if (tab_wrap) begin
              col_nxt = '0;
              row_nxt = nl_row[DIM_W-1:0];
            end else begin
              col_nxt = tab_col[DIM_W-1:0];
            end
          end else begin
            q_push  = fits;
            row_nxt = row2[DIM_W-1:0];
            col_nxt = DIM_W'(col2 + CELL_E);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // cursor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tcgr_back.sv
// back end: runs queued commands, owns the font store, emits glyph pixels
// depends on tcgr_pkg and tcgr_ram
`default_nettype none

module tcgr_back
  import tcgr_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
  parameter int AW          = $clog2(GLYPH_COUNT * CELL),
  parameter int QW          = 1 + 2 * POS_W + AW + 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [QW-1:0]      q_data,
  input  tcgr_q_stat_t            q_stat,
  output logic                    q_pop,
  input  wire logic [COLOR_W-1:0] fore_color,
  input  wire logic [COLOR_W-1:0] back_color,
  output logic                    out_valid,
  output tcgr_pixel_t             out_pixel,
  input  wire logic               out_ready
);

  localparam logic [2:0] LAST_IDX = 3'(CELL - 1);

  tcgr_bstate_t state_r, state_nxt;

  logic [POS_W-1:0] x_r, x_nxt;
  logic [POS_W-1:0] y_r, y_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic [2:0]       row_r, row_nxt;
  logic [2:0]       col_r, col_nxt;
  logic [7:0]       bits_r, bits_nxt;
  logic             out_valid_r, out_valid_nxt;
  tcgr_pixel_t      out_r, out_nxt;

  tcgr_cmd_t        h_kind;
  logic [POS_W-1:0] h_x, h_y;
  logic [AW-1:0]    h_addr;
  logic [7:0]       h_bits;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          emit_ok;
  tcgr_pixel_t   pix;

  // queue head fields
  assign h_kind = tcgr_cmd_t'(q_data[QW-1]);
  assign h_x    = q_data[QW-2 -: POS_W];
  assign h_y    = q_data[QW-2-POS_W -: POS_W];
  assign h_addr = q_data[8 +: AW];
  assign h_bits = q_data[7:0];

  // font store
  tcgr_ram #(
    .WIDTH(8),
    .DEPTH(GLYPH_COUNT * CELL)
  ) u_font (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // pixel under the draw counters
  assign pix.pixel_x     = x_r + POS_W'(col_r);
  assign pix.pixel_y     = y_r + POS_W'(row_r);
  assign pix.pixel_color = bits_r[col_r] ? fore_color : back_color;
  assign pix.last_pixel  = (row_r == LAST_IDX) && (col_r == LAST_IDX);

  assign emit_ok = !out_valid_r || out_ready;

  // sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    base_nxt      = base_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    bits_nxt      = bits_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = h_addr;
    ram_wdata     = h_bits;
    ram_re        = 1'b0;
    ram_raddr     = h_addr;
    case (state_r)
      BS_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          if (h_kind == CMD_LOAD) begin
            ram_we = 1'b1;
          end else begin
            ram_re    = 1'b1;
            x_nxt     = h_x;
            y_nxt     = h_y;
            base_nxt  = h_addr;
            state_nxt = BS_FETCH;
          end
        end
      end
      BS_FETCH: begin
        // top row arrives, prefetch the second
        bits_nxt  = ram_rdata;
        row_nxt   = '0;
        col_nxt   = '0;
        ram_re    = 1'b1;
        ram_raddr = base_r + AW'(1);
        state_nxt = BS_DRAW;
      end
      BS_DRAW: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pix;
          col_nxt       = col_r + 1'b1;
          if (col_r == LAST_IDX) begin
            if (row_r == LAST_IDX) begin
              state_nxt = BS_IDLE;
            end else begin
              bits_nxt  = ram_rdata;
              row_nxt   = row_r + 1'b1;
              ram_re    = (row_r < LAST_IDX - 3'd1);
              ram_raddr = base_r + AW'(row_r) + AW'(2);
            end
          end
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    base_r <= base_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    bits_r <= bits_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_r;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench for text_console_glyph_renderer
// predicts every pixel transfer from the accepted items and register writes
// depends on tcgr_pkg and the renderer rtl only

module testbench;
  import tcgr_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int SETTLE_CYCLES = 300;
  localparam int PHASE_ITEMS = 33;
  localparam int RUN_LIMIT_CYCLES = 1_500_000;

  // expected pixel stream of the console, kept from accepted items
  class console_tracker;
    logic [12:0] scr_width;
    logic [12:0] scr_height;
    logic [31:0] fore;
    logic [31:0] back;
    logic [12:0] col;
    logic [12:0] row;
    logic [7:0] font [GLYPH_COUNT_DEF*CELL];
    bit written [GLYPH_COUNT_DEF*CELL];
    tcgr_pixel_t due_pixels[$];
    int errors;

    function new();
      scr_width = WIDTH_RST;
      scr_height = HEIGHT_RST;
      fore = FORE_RST;
      back = BACK_RST;
      col = '0;
      row = '0;
      errors = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void write_reg(tcgr_reg_t r, logic [31:0] v);
      case (r)
        REG_WIDTH: scr_width = v[12:0];
        REG_HEIGHT: scr_height = v[12:0];
        REG_FORE: fore = v;
        REG_BACK: back = v;
        default: ;
      endcase
    endfunction

    function bit glyph_ready(int g);
      for (int r = 0; r < CELL; r++)
        if (!written[g*CELL + r]) return 1'b0;
      return 1'b1;
    endfunction

    function int pending();
      return due_pixels.size();
    endfunction

    // screen size clamps at the largest supported dimension
    function int unsigned clamp_dim(logic [12:0] d);
      return (d > MAX_SCREEN_DIM_DEF) ? MAX_SCREEN_DIM_DEF : d;
    endfunction

    // one text line down, back to the top when the next line does not fit
    function void line_down(int unsigned h);
      int unsigned r;
      r = row + CELL;
      if (r + CELL > h) r = 0;
      row = 13'(r);
    endfunction

    function void accept_item(tcgr_item_t it);
      int unsigned w, h, c, g, bits;
      int n;
      tcgr_pixel_t px;
      w = clamp_dim(scr_width);
      h = clamp_dim(scr_height);
      case (it.operation)
        OP_CURSOR: begin
          col = {1'b0, it.pos_x};
          row = {1'b0, it.pos_y};
        end
        OP_LOAD: begin
          if (it.glyph_index < GLYPH_COUNT_DEF) begin
            font[it.glyph_index*CELL + it.glyph_row] = it.glyph_bits;
            written[it.glyph_index*CELL + it.glyph_row] = 1'b1;
          end
        end
        OP_PRINT: begin
          if (it.char_code == CODE_NEWLINE) begin
            col = '0;
            line_down(h);
          end else if (it.char_code == CODE_RETURN) begin
            col = '0;
          end else if (it.char_code == CODE_TAB) begin
            c = (col / CELL + 4) * CELL;
            if (c + CELL > w) begin
              c = 0;
              line_down(h);
            end
            col = 13'(c);
          end else begin
            // wrap, clip to the screen, then draw if the cell fits
            if (col + CELL > w) begin
              col = '0;
              line_down(h);
            end
            if (row + CELL > h) row = '0;
            if (col + CELL > w) col = '0;
            if (col + CELL <= w && row + CELL <= h) begin
              g = (it.char_code < GLYPH_COUNT_DEF) ? it.char_code : 0;
              n = 0;
              for (int r = 0; r < CELL; r++) begin
                bits = font[g*CELL + r];
                for (int k = 0; k < CELL; k++) begin
                  px.pixel_x = 12'(col + k);
                  px.pixel_y = 12'(row + r);
                  px.pixel_color = bits[k] ? fore : back;
                  px.last_pixel = (n == CELL*CELL - 1);
                  due_pixels.push_back(px);
                  n++;
                end
              end
            end
            col = 13'(col + CELL);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(tcgr_pixel_t got);
      tcgr_pixel_t want;
      if (due_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d", got.pixel_x, got.pixel_y);
        errors++;
        return;
      end
      want = due_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x) begin
        $error("pixel_x expected %0d got %0d", want.pixel_x, got.pixel_x);
        errors++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $error("pixel_y expected %0d got %0d", want.pixel_y, got.pixel_y);
        errors++;
      end
      if (got.pixel_color !== want.pixel_color) begin
        $error("pixel_color expected %h got %h", want.pixel_color, got.pixel_color);
        errors++;
      end
      if (got.last_pixel !== want.last_pixel) begin
        $error("last_pixel expected %0d got %0d", want.last_pixel, got.last_pixel);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  tcgr_item_t in_item;
  logic in_ready;
  logic out_valid;
  tcgr_pixel_t out_pixel;
  logic out_ready;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  console_tracker tracker;
  bit tx_calm;
  bit rx_calm;

  text_console_glyph_renderer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_item(in_item),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_pixel(out_pixel),
    .out_ready(out_ready),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // check every pixel transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_pixel(out_pixel);
  end

  // item with every field random, callers then fix the fields that matter
  function automatic tcgr_item_t noise_item();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(tcgr_item_t)-1:0];
  endfunction

  function automatic tcgr_item_t print_item(logic [7:0] code);
    tcgr_item_t it;
    it = noise_item();
    it.operation = OP_PRINT;
    it.char_code = code;
    return it;
  endfunction

  function automatic tcgr_item_t cursor_item(int x, int y);
    tcgr_item_t it;
    it = noise_item();
    it.operation = OP_CURSOR;
    it.pos_x = 12'(x);
    it.pos_y = 12'(y);
    return it;
  endfunction

  function automatic tcgr_item_t load_item(int g, int r, int bits);
    tcgr_item_t it;
    it = noise_item();
    it.operation = OP_LOAD;
    it.glyph_index = 7'(g);
    it.glyph_row = 3'(r);
    it.glyph_bits = 8'(bits);
    return it;
  endfunction

  // a printable code whose glyph is fully loaded, now and then a code above the glyph range
  function automatic logic [7:0] pick_code();
    int ready_codes[$];
    for (int g = 0; g < GLYPH_COUNT_DEF; g++)
      if (tracker.glyph_ready(g) && g != CODE_TAB && g != CODE_NEWLINE
          && g != CODE_RETURN)
        ready_codes.push_back(g);
    if (ready_codes.size() == 0 || $urandom_range(0, 4) == 0)
      return 8'($urandom_range(128, 255));
    return 8'(ready_codes[$urandom_range(0, ready_codes.size() - 1)]);
  endfunction

  // one input transfer, called and returning at a falling edge
  task automatic send(tcgr_item_t it);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    tracker.accept_item(it);
    @(negedge clk);
  endtask

  // stop sending until every expected pixel is out, then let the block settle
  task automatic hold_input(int extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
    repeat (extra) @(negedge clk);
  endtask

  // register write: setup phase, access phase, then an idle phase
  task automatic cfg_write(tcgr_reg_t r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.write_reg(r, v);
    @(negedge clk);
  endtask

  task automatic apply_setting(int w, int h, logic [31:0] fg, logic [31:0] bg);
    cfg_write(REG_WIDTH, 32'(w));
    cfg_write(REG_HEIGHT, 32'(h));
    cfg_write(REG_FORE, fg);
    cfg_write(REG_BACK, bg);
  endtask

  // short directed sequence at the reset screen size
  task automatic run_directed();
    int row_bits [CELL] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0};
    for (int r = 0; r < CELL; r++) send(load_item(0, r, row_bits[r]));
    send(print_item(8'd0));
    send(print_item(8'd255));
    send(print_item(8'd128));
    send(print_item(CODE_TAB));
    send(print_item(CODE_RETURN));
    send(print_item(CODE_NEWLINE));
    // cursor far off screen wraps to the top left
    send(cursor_item(4095, 4095));
    send(print_item(8'd0));
    send(cursor_item(0, 0));
    send('1);
    send(load_item(127, 7, 8'hFF));
    // last cell of the screen, then wrap back to the top
    send(cursor_item(632, 472));
    send(print_item(8'd128));
    send(print_item(8'd0));
    // tab that fits, then tab past the right edge
    send(cursor_item(600, 0));
    send(print_item(CODE_TAB));
    send(print_item(CODE_TAB));
  endtask

  task automatic run_random(int count);
    int sent, choice, g, len, x_lim, y_lim;
    tcgr_item_t it;
    sent = 0;
    while (sent < count) begin
      choice = $urandom_range(0, 99);
      if (choice < 12) begin
        // full glyph load followed by a print of it
        g = $urandom_range(0, GLYPH_COUNT_DEF - 1);
        for (int r = 0; r < CELL; r++) send(load_item(g, r, $urandom_range(0, 255)));
        send(print_item(8'(g)));
        sent += CELL + 1;
      end else if (choice < 17) begin
        send(load_item($urandom_range(0, 127), $urandom_range(0, 7), $urandom_range(0, 255)));
        sent++;
      end else if (choice < 27) begin
        x_lim = (tracker.scr_width > 4095) ? 4095 : tracker.scr_width;
        y_lim = (tracker.scr_height > 4095) ? 4095 : tracker.scr_height;
        if ($urandom_range(0, 1))
          send(cursor_item($urandom_range(0, 4095), $urandom_range(0, 4095)));
        else
          send(cursor_item($urandom_range(0, x_lim), $urandom_range(0, y_lim)));
        sent++;
      end else if (choice < 37) begin
        case ($urandom_range(0, 2))
          0: send(print_item(CODE_TAB));
          1: send(print_item(CODE_NEWLINE));
          default: send(print_item(CODE_RETURN));
        endcase
        sent++;
      end else if (choice < 41) begin
        it = noise_item();
        it.operation = OP_NONE;
        send(it);
        sent++;
      end else if (choice < 44) begin
        hold_input(0);
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) send(print_item(pick_code()));
        sent += len;
      end
    end
  endtask

  // output side stalls, one pixel per transfer
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!rx_calm && $urandom_range(0, 1)) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // stimulus and end of run
  initial begin
    tracker = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        hold_input(SETTLE_CYCLES);
        case (p)
          1: apply_setting(8191, 8191, 32'h0000_0000, 32'hFFFF_FFFF);
          2: apply_setting(8, 8, 32'hFFFF_FFFF, 32'h0000_0000);
          3: apply_setting(0, 7, $urandom(), $urandom());
          4: apply_setting(4096, 4096, $urandom(), $urandom());
          5: apply_setting($urandom_range(8, 4096), $urandom_range(8, 4096),
                           $urandom(), $urandom());
          default: apply_setting(12, 20, $urandom(), $urandom());
        endcase
      end
      // no-stall stretches on both sides, forced once
      tx_calm = (p == 2) || ($urandom_range(0, 3) == 0);
      rx_calm = (p == 2) || ($urandom_range(0, 3) == 0);
      run_random(PHASE_ITEMS);
    end
    hold_input(SETTLE_CYCLES);
    if (tracker.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // watchdog
  initial begin
    #(2 * HALF_PERIOD * RUN_LIMIT_CYCLES);
    $display("tb: failure");
    $finish;
  end

endmodule
